@@ sv/kfrp_pkg.sv @@
// Shared codes and address constants for the font ROM port.
package kfrp_pkg;

  localparam int unsigned OpW = 2;

  localparam logic [OpW-1:0] OP_READ  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_LOAD  = 2'd2;

  localparam logic [1:0] SEL_LEVEL1 = 2'd0;
  localparam logic [1:0] SEL_LEGACY = 2'd1;
  localparam logic [1:0] SEL_LEVEL2 = 2'd2;

  localparam logic [15:0] ADDR_HI      = 16'hfd20;
  localparam logic [15:0] ADDR_LO      = 16'hfd21;
  localparam logic [15:0] ADDR_L1_LEFT = 16'hfd22;
  localparam logic [15:0] ADDR_L1_RGHT = 16'hfd23;
  localparam logic [15:0] ADDR_HI2     = 16'hfd2c;
  localparam logic [15:0] ADDR_LO2     = 16'hfd2d;
  localparam logic [15:0] ADDR_BANK    = 16'hfd2e;
  localparam logic [15:0] ADDR_L2_RGHT = 16'hfd2f;

  localparam logic [3:0] UNDEF_WINDOW = 4'h3;  // char address 0x3000..0x3fff
  localparam logic [7:0] BYTE_FF      = 8'hff;
  localparam logic [5:0] BANK_MASK    = 6'h3f;

  localparam logic [2:0] VER_LEVEL2  = 3'd2;
  localparam logic [2:0] VER_CURRENT = 3'd3;

  localparam logic [1:0] CFG_VERSION = 2'd0;
  localparam logic [1:0] CFG_SUBSYS  = 2'd1;
  localparam logic [1:0] CFG_CARD    = 2'd2;
  localparam logic [1:0] CFG_KEEP    = 2'd3;

  // Where a result byte comes from.
  localparam logic [1:0] SRC_CONST  = 2'd0;
  localparam logic [1:0] SRC_LEVEL1 = 2'd1;
  localparam logic [1:0] SRC_LEGACY = 2'd2;
  localparam logic [1:0] SRC_LEVEL2 = 2'd3;

endpackage

@@ sv/kfrp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kfrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/kanji_font_rom_port_unit.sv @@
// Font ROM port top level: address/bank registers and three font ROMs.
//
// Takes one word per cycle while in_stall_o is low and returns one result
// word per accepted word, through stage 1 and then the output register.
// Stage 1 follows from the registered ROM read: a data read addresses the ROM
// in the accept cycle and the byte is selected in the following stage. One
// word can wait in that stage while a finished result waits at the output.
// The ROM contents are not cleared by reset; a data read of a ROM byte that
// was never loaded returns an arbitrary value. No start-up sweep is needed.
module kanji_font_rom_port_unit import kfrp_pkg::*; #(
  parameter int unsigned ROM_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [1:0]  rom_select_i,
  input  logic [16:0] rom_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        claimed_o,
  output logic        dict_ram_enable_o,
  output logic        dict_rom_enable_o,
  output logic [5:0]  dict_rom_bank_o
);

  localparam int unsigned AW = $clog2(ROM_BYTES);

  // configuration
  logic [2:0] version_q;
  logic       subsys_q, card_q, keep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VER_CURRENT;
      subsys_q  <= 1'b0;
      card_q    <= 1'b0;
      keep_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VERSION: version_q <= cfg_wdata_i;
        CFG_SUBSYS:  subsys_q  <= cfg_wdata_i[0];
        CFG_CARD:    card_q    <= cfg_wdata_i[0];
        CFG_KEEP:    keep_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic ver_old, ver_cur, lvl2_ok;
  assign ver_old = (version_q < VER_LEVEL2);
  assign ver_cur = (version_q >= VER_CURRENT);
  assign lvl2_ok = ver_cur || (version_q == VER_LEVEL2 && card_q);

  // handshake
  logic s1_valid_q, out_valid_q, s1_adv, in_acc;
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // architectural registers
  logic [15:0] char_addr_q, char_addr_d;
  logic        ram_en_q, ram_en_d, rom_en_q, rom_en_d;
  logic [5:0]  bank_q, bank_d;

  // stage 0 decode
  logic       side;
  logic [1:0] src;
  logic [7:0] cval;
  logic       claim;

  assign side = bus_address_i[0];

  always_comb begin
    char_addr_d = char_addr_q;
    ram_en_d    = ram_en_q;
    rom_en_d    = rom_en_q;
    bank_d      = bank_q;
    src         = SRC_CONST;
    cval        = 8'h00;
    claim       = 1'b0;
    case (operation_i)
      OP_READ: begin
        case (bus_address_i)
          ADDR_HI, ADDR_LO, ADDR_HI2, ADDR_LO2: begin
            claim = 1'b1;
            cval  = BYTE_FF;
          end
          ADDR_L1_LEFT, ADDR_L1_RGHT: begin
            claim = 1'b1;
            if (subsys_q) begin
              cval = BYTE_FF;
            end else if (ver_old && !keep_q && char_addr_q[15:12] == UNDEF_WINDOW) begin
              cval = {7'd0, side};
            end else if (ver_cur) begin
              src = SRC_LEVEL1;
            end else begin
              src = SRC_LEGACY;
            end
          end
          ADDR_BANK, ADDR_L2_RGHT: begin
            claim = 1'b1;
            if (subsys_q || !lvl2_ok) begin
              cval = BYTE_FF;
            end else begin
              src = SRC_LEVEL2;
            end
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (bus_address_i)
          ADDR_HI: begin
            claim = 1'b1;
            char_addr_d[15:8] = write_data_i;
          end
          ADDR_HI2: begin
            claim = 1'b1;
            if (!ver_old) char_addr_d[15:8] = write_data_i;
          end
          ADDR_LO: begin
            claim = 1'b1;
            char_addr_d[7:0] = write_data_i;
          end
          ADDR_LO2: begin
            claim = 1'b1;
            if (!ver_old) char_addr_d[7:0] = write_data_i;
          end
          ADDR_L1_LEFT, ADDR_L1_RGHT, ADDR_L2_RGHT: begin
            claim = 1'b1;
          end
          ADDR_BANK: begin
            claim = 1'b1;
            if (lvl2_ok) begin
              ram_en_d = write_data_i[7];
              rom_en_d = write_data_i[6];
              bank_d   = write_data_i[5:0] & BANK_MASK;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_addr_q <= 16'h0000;
      ram_en_q    <= 1'b0;
      rom_en_q    <= 1'b0;
      bank_q      <= 6'd0;
    end else if (in_acc) begin
      char_addr_q <= char_addr_d;
      ram_en_q    <= ram_en_d;
      rom_en_q    <= rom_en_d;
      bank_q      <= bank_d;
    end
  end

  // ROM addressing: 2*char_address + side, folded once into the ROM range
  logic [17:0] pos;
  logic [17:0] pos_wrap;
  logic [AW-1:0] raddr, waddr;
  logic        load_ok;

  assign pos      = {1'b0, char_addr_q, side};
  assign pos_wrap = (pos >= 18'(ROM_BYTES)) ? pos - 18'(ROM_BYTES) : pos;
  assign raddr    = pos_wrap[AW-1:0];
  assign load_ok  = in_acc && operation_i == OP_LOAD && {1'b0, rom_index_i} < 18'(ROM_BYTES);
  assign waddr    = rom_index_i[AW-1:0];

  logic [2:0] re, we;
  assign re[0] = in_acc && src == SRC_LEVEL1;
  assign re[1] = in_acc && src == SRC_LEGACY;
  assign re[2] = in_acc && src == SRC_LEVEL2;
  assign we[0] = load_ok && rom_select_i == SEL_LEVEL1;
  assign we[1] = load_ok && rom_select_i == SEL_LEGACY;
  assign we[2] = load_ok && rom_select_i == SEL_LEVEL2;

  logic [7:0] rdata [3];

  for (genvar g = 0; g < 3; g++) begin : g_rom
    kfrp_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(waddr),
      .wdata_i(write_data_i),
      .re_i   (re[g]),
      .raddr_i(raddr),
      .rdata_o(rdata[g])
    );
  end

  // stage 1: waits for ROM data; ROM read data holds while this stage stalls
  logic [1:0] s1_src_q;
  logic [7:0] s1_cval_q;
  logic       s1_claim_q, s1_ram_en_q, s1_rom_en_q;
  logic [5:0] s1_bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_src_q    <= src;
      s1_cval_q   <= cval;
      s1_claim_q  <= claim;
      s1_ram_en_q <= ram_en_d;
      s1_rom_en_q <= rom_en_d;
      s1_bank_q   <= bank_d;
    end
  end

  logic [7:0] s1_byte;
  always_comb begin
    case (s1_src_q)
      SRC_LEVEL1: s1_byte = rdata[0];
      SRC_LEGACY: s1_byte = rdata[1];
      SRC_LEVEL2: s1_byte = rdata[2];
      default:    s1_byte = s1_cval_q;
    endcase
  end

  // output register
  logic [7:0] rd_q;
  logic       claim_q, o_ram_en_q, o_rom_en_q;
  logic [5:0] o_bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      rd_q       <= s1_byte;
      claim_q    <= s1_claim_q;
      o_ram_en_q <= s1_ram_en_q;
      o_rom_en_q <= s1_rom_en_q;
      o_bank_q   <= s1_bank_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = rd_q;
  assign claimed_o         = claim_q;
  assign dict_ram_enable_o = o_ram_en_q;
  assign dict_rom_enable_o = o_rom_en_q;
  assign dict_rom_bank_o   = o_bank_q;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while a stage is free");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_src_q) && $stable(s1_byte)))
    else $error("stalled ROM word changed");

  a_one_rom_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(re))
    else $error("more than one ROM read at once");

  a_unclaimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !claim_q) |-> (rd_q == 8'h00))
    else $error("unclaimed word returned data");

endmodule
